>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion shorthands for the camera update block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define CETU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CETU_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cetu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetu_pkg
// Widths, fixed-point constants, types and the arctangent table shared by
// the camera eye/target update block.
// ----------------------------------------------------------------------------
package cetu_pkg;

  // Field widths
  localparam int COORD_WIDTH  = 32;
  localparam int ANGLE_WIDTH  = 16;
  localparam int CORDIC_STEPS = 16;

  // Fixed-point formats
  localparam int COORD_FRAC   = 16;
  localparam int TRIG_FRAC    = 30;
  localparam int ANGLE_TO_Q30 = 18;

  // Internal widths
  localparam int V_W     = COORD_WIDTH + 1;   // eye-to-target vector
  localparam int T_W     = 33;                // sine/cosine, Q.30 with headroom
  localparam int Z_W     = 20;                // CORDIC residual angle, Q.16
  localparam int RED_W   = (ANGLE_WIDTH + ANGLE_TO_Q30 > 35) ?
                           ANGLE_WIDTH + ANGLE_TO_Q30 + 1 : 36;
  localparam int STEP_W  = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // Sequential multiplier
  localparam int MA_W       = (V_W > T_W) ? V_W : T_W;
  localparam int CHUNK_W    = 17;
  localparam int MUL_CHUNKS = (MA_W + CHUNK_W - 1) / CHUNK_W;
  localparam int MBP_W      = MUL_CHUNKS * CHUNK_W;
  localparam int ACC_W      = 2 * MA_W;
  localparam int RND_W      = ACC_W + 1;
  localparam int CCNT_W     = $clog2(MUL_CHUNKS + 1);
  localparam int LIMIT_LOG2 = 60;
  localparam int TERM_W     = LIMIT_LOG2 + 2;
  localparam int SUM_W      = ((COORD_WIDTH > TERM_W) ? COORD_WIDTH : TERM_W) + 2;

  // Stream payload widths
  localparam int IN_DATA_W  = ((7 * COORD_WIDTH + 3 * ANGLE_WIDTH + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((6 * COORD_WIDTH + 7) / 8) * 8;
  localparam int OP_W       = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PLACE  = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd2;

  // Angle constants in Q.30 radians
  localparam logic signed [RED_W-1:0] PI_Q30      = RED_W'(64'd3373259426);
  localparam logic signed [RED_W-1:0] HALF_PI_Q30 = RED_W'(64'd1686629713);
  localparam logic signed [RED_W-1:0] TWO_PI_Q30  = RED_W'(64'd6746518852);
  localparam logic signed [T_W-1:0]   GAIN_Q30    = T_W'(64'd652032874);

  // Multiplier request
  typedef struct packed {
    logic start;
    logic trig;    // 1: Q.30 product scale, 0: Q.16 product scale
  } mul_req_t;

  // CORDIC arctangent table, Q.16 radians
  function automatic logic signed [Z_W-1:0] atan_q16(input logic [4:0] idx);
    logic signed [Z_W-1:0] v;
    case (idx)
      5'd0:    v = Z_W'(51472);
      5'd1:    v = Z_W'(30386);
      5'd2:    v = Z_W'(16055);
      5'd3:    v = Z_W'(8150);
      5'd4:    v = Z_W'(4091);
      5'd5:    v = Z_W'(2047);
      5'd6:    v = Z_W'(1024);
      5'd7:    v = Z_W'(512);
      5'd8:    v = Z_W'(256);
      5'd9:    v = Z_W'(128);
      5'd10:   v = Z_W'(64);
      5'd11:   v = Z_W'(32);
      5'd12:   v = Z_W'(16);
      5'd13:   v = Z_W'(8);
      5'd14:   v = Z_W'(4);
      5'd15:   v = Z_W'(2);
      5'd16:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> src/cetu_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetu_mul
// Sign-magnitude sequential multiplier: one CHUNK_W-bit slice of the second
// operand per cycle, then a rounding phase (half away from zero, Q.16 or
// Q.30 scale) with the magnitude clamped to 2^60.
// ----------------------------------------------------------------------------
module cetu_mul import cetu_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mul_req_t                 req,
  input  logic signed [MA_W-1:0]   op_a,
  input  logic signed [MA_W-1:0]   op_b,
  output logic                     done,
  output logic signed [TERM_W-1:0] term
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_MULT  = 2'd1;
  localparam logic [1:0] PH_ROUND = 2'd2;

  localparam logic [RND_W-1:0] HALF_MOVE = RND_W'(1) << (COORD_FRAC - 1);
  localparam logic [RND_W-1:0] HALF_TRIG = RND_W'(1) << (TRIG_FRAC - 1);
  localparam logic [RND_W-1:0] MAG_LIMIT = RND_W'(1) << LIMIT_LOG2;

  logic [1:0]               phase_r, phase_nxt;
  logic [CCNT_W-1:0]        cnt_r, cnt_nxt;
  logic [MA_W-1:0]          ma_r, ma_nxt;
  logic [MBP_W-1:0]         mb_r, mb_nxt;
  logic [ACC_W-1:0]         acc_r, acc_nxt;
  logic                     neg_r, neg_nxt;
  logic                     trig_r, trig_nxt;
  logic                     done_r, done_nxt;
  logic signed [TERM_W-1:0] term_r, term_nxt;

  logic [MA_W-1:0]          mag_a, mag_b;
  logic [MA_W+CHUNK_W-1:0]  part;
  logic [RND_W-1:0]         rnd, shifted, mag;

  // Sequencer and datapath
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    ma_nxt    = ma_r;
    mb_nxt    = mb_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    trig_nxt  = trig_r;
    term_nxt  = term_r;
    done_nxt  = 1'b0;

    mag_a   = op_a[MA_W-1] ? MA_W'(-op_a) : MA_W'(op_a);
    mag_b   = op_b[MA_W-1] ? MA_W'(-op_b) : MA_W'(op_b);
    part    = ma_r * mb_r[MBP_W-1 -: CHUNK_W];
    rnd     = {1'b0, acc_r} + (trig_r ? HALF_TRIG : HALF_MOVE);
    shifted = trig_r ? (rnd >> TRIG_FRAC) : (rnd >> COORD_FRAC);
    mag     = (shifted > MAG_LIMIT) ? MAG_LIMIT : shifted;

    case (phase_r)
      PH_IDLE: begin
        if (req.start) begin
          ma_nxt    = mag_a;
          mb_nxt    = MBP_W'(mag_b);
          acc_nxt   = '0;
          neg_nxt   = op_a[MA_W-1] ^ op_b[MA_W-1];
          trig_nxt  = req.trig;
          cnt_nxt   = CCNT_W'(MUL_CHUNKS);
          phase_nxt = PH_MULT;
        end
      end
      PH_MULT: begin
        // most significant slice first
        acc_nxt = (acc_r << CHUNK_W) + ACC_W'(part);
        mb_nxt  = mb_r << CHUNK_W;
        cnt_nxt = cnt_r - CCNT_W'(1);
        if (cnt_r == CCNT_W'(1)) begin
          phase_nxt = PH_ROUND;
        end
      end
      PH_ROUND: begin
        term_nxt  = neg_r ? -TERM_W'(mag) : TERM_W'(mag);
        done_nxt  = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ma_r   <= ma_nxt;
    mb_r   <= mb_nxt;
    acc_r  <= acc_nxt;
    neg_r  <= neg_nxt;
    trig_r <= trig_nxt;
    term_r <= term_nxt;
  end

  assign done = done_r;
  assign term = term_r;

endmodule

>>> src/cetu_sincos.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetu_sincos
// Sine and cosine of a Q4.12 angle: range reduction by repeated 2*pi steps,
// wrap and fold into [-pi/2, pi/2], then a rotation-mode CORDIC with one
// step per cycle through a shared barrel shifter. Results are Q.30.
// ----------------------------------------------------------------------------
module cetu_sincos import cetu_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  output logic                          done,
  output logic signed [T_W-1:0]         sin_val,
  output logic signed [T_W-1:0]         cos_val
);

  localparam logic [2:0] SC_IDLE   = 3'd0;
  localparam logic [2:0] SC_REDUCE = 3'd1;
  localparam logic [2:0] SC_WRAP   = 3'd2;
  localparam logic [2:0] SC_FOLD   = 3'd3;
  localparam logic [2:0] SC_ROT    = 3'd4;
  localparam logic [2:0] SC_OUT    = 3'd5;

  localparam int Z_SHIFT = TRIG_FRAC - COORD_FRAC;
  localparam logic signed [RED_W-1:0] Z_HALF = RED_W'(1 << (Z_SHIFT - 1));

  logic [2:0]              phase_r, phase_nxt;
  logic [STEP_W-1:0]       i_r, i_nxt;
  logic                    done_r, done_nxt;
  logic signed [RED_W-1:0] r_r, r_nxt;
  logic                    flip_r, flip_nxt;
  logic signed [T_W-1:0]   x_r, x_nxt;
  logic signed [T_W-1:0]   y_r, y_nxt;
  logic signed [Z_W-1:0]   z_r, z_nxt;
  logic signed [T_W-1:0]   sin_r, sin_nxt;
  logic signed [T_W-1:0]   cos_r, cos_nxt;

  logic signed [RED_W-1:0] rf;
  logic                    fold;
  logic signed [T_W-1:0]   xs, ys;
  logic signed [Z_W-1:0]   at;

  always_comb begin
    phase_nxt = phase_r;
    i_nxt     = i_r;
    done_nxt  = 1'b0;
    r_nxt     = r_r;
    flip_nxt  = flip_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    sin_nxt   = sin_r;
    cos_nxt   = cos_r;

    // fold into [-pi/2, pi/2]; folding negates the cosine
    rf   = r_r;
    fold = 1'b0;
    if (r_r > HALF_PI_Q30) begin
      rf   = PI_Q30 - r_r;
      fold = 1'b1;
    end else if (r_r < -HALF_PI_Q30) begin
      rf   = -PI_Q30 - r_r;
      fold = 1'b1;
    end

    // CORDIC step operands
    xs = x_r >>> i_r;
    ys = y_r >>> i_r;
    at = atan_q16(5'(i_r));

    case (phase_r)
      SC_IDLE: begin
        if (start) begin
          r_nxt     = RED_W'(angle) <<< ANGLE_TO_Q30;
          phase_nxt = SC_REDUCE;
        end
      end
      SC_REDUCE: begin
        // remainder toward zero, one 2*pi per cycle
        if (r_r >= TWO_PI_Q30) begin
          r_nxt = r_r - TWO_PI_Q30;
        end else if (r_r <= -TWO_PI_Q30) begin
          r_nxt = r_r + TWO_PI_Q30;
        end else begin
          phase_nxt = SC_WRAP;
        end
      end
      SC_WRAP: begin
        if (r_r > PI_Q30) begin
          r_nxt = r_r - TWO_PI_Q30;
        end else if (r_r < -PI_Q30) begin
          r_nxt = r_r + TWO_PI_Q30;
        end
        phase_nxt = SC_FOLD;
      end
      SC_FOLD: begin
        flip_nxt  = fold;
        z_nxt     = Z_W'((rf + Z_HALF) >>> Z_SHIFT);
        x_nxt     = GAIN_Q30;
        y_nxt     = '0;
        i_nxt     = '0;
        phase_nxt = SC_ROT;
      end
      SC_ROT: begin
        if (!z_r[Z_W-1]) begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end else begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end
        if (i_r == STEP_W'(CORDIC_STEPS - 1)) begin
          phase_nxt = SC_OUT;
        end else begin
          i_nxt = i_r + STEP_W'(1);
        end
      end
      SC_OUT: begin
        sin_nxt   = y_r;
        cos_nxt   = flip_r ? -x_r : x_r;
        done_nxt  = 1'b1;
        phase_nxt = SC_IDLE;
      end
      default: begin
        phase_nxt = SC_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= SC_IDLE;
      i_r     <= '0;
      done_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      i_r     <= i_nxt;
      done_r  <= done_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    r_r    <= r_nxt;
    flip_r <= flip_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    sin_r  <= sin_nxt;
    cos_r  <= cos_nxt;
  end

  assign done    = done_r;
  assign sin_val = sin_r;
  assign cos_val = cos_r;

endmodule

>>> src/camera_eye_target_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// camera_eye_target_update
// Look-at camera state: eye and target points in signed Q16.16, updated by
// place, move along view, and rotate view requests.
// ----------------------------------------------------------------------------
// One request is worked on at a time and every request returns both points
// on the output stream. Move makes two products on the shared sequential
// multiplier, each as load, two 17-bit slices, round. Rotate makes, for
// each nonzero angle, a pass through the sine/cosine unit (one or two
// range-reduction steps, wrap, fold, one CORDIC step per cycle, 16 steps)
// followed by four products on the multiplier. A new request is taken
// while a finished result still waits on the output.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module camera_eye_target_update import cetu_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata, lowest bit up: load_pos_x, load_pos_y, load_pos_z,
  // load_view_x, load_view_y, load_view_z, move_speed, turn_x, turn_y, turn_z
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // in_tuser: operation
  input  logic [OP_W-1:0]       in_tuser,
  // out_tdata, lowest bit up: out_eye_x, out_eye_y, out_eye_z,
  // out_target_x, out_target_y, out_target_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  // Sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_DISPATCH = 4'd1;
  localparam logic [3:0] ST_MOVE_X   = 4'd2;
  localparam logic [3:0] ST_MOVE_Z   = 4'd3;
  localparam logic [3:0] ST_AXIS     = 4'd4;
  localparam logic [3:0] ST_TRIG     = 4'd5;
  localparam logic [3:0] ST_P0       = 4'd6;
  localparam logic [3:0] ST_P1       = 4'd7;
  localparam logic [3:0] ST_P2       = 4'd8;
  localparam logic [3:0] ST_P3       = 4'd9;
  localparam logic [3:0] ST_DONE     = 4'd10;

  // Rotation axes
  localparam logic [1:0] AX_X   = 2'd0;
  localparam logic [1:0] AX_Y   = 2'd1;
  localparam logic [1:0] AX_Z   = 2'd2;
  localparam logic [1:0] AX_END = 2'd3;

  localparam logic signed [SUM_W-1:0] C_MAX = SUM_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
  localparam logic signed [SUM_W-1:0] C_MIN = -C_MAX - SUM_W'(1);

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
    input logic signed [SUM_W-1:0] v
  );
    logic signed [COORD_WIDTH-1:0] s;
    if (v > C_MAX) begin
      s = C_MAX[COORD_WIDTH-1:0];
    end else if (v < C_MIN) begin
      s = C_MIN[COORD_WIDTH-1:0];
    end else begin
      s = v[COORD_WIDTH-1:0];
    end
    return s;
  endfunction

  // State and working registers
  logic [3:0]                    state_r, state_nxt;
  logic [1:0]                    axis_r, axis_nxt;
  logic [OP_W-1:0]               op_r, op_nxt;
  logic signed [COORD_WIDTH-1:0] eye_x_r, eye_x_nxt, eye_y_r, eye_y_nxt;
  logic signed [COORD_WIDTH-1:0] eye_z_r, eye_z_nxt;
  logic signed [COORD_WIDTH-1:0] tgt_x_r, tgt_x_nxt, tgt_y_r, tgt_y_nxt;
  logic signed [COORD_WIDTH-1:0] tgt_z_r, tgt_z_nxt;
  logic signed [V_W-1:0]         v_x_r, v_x_nxt, v_y_r, v_y_nxt, v_z_r, v_z_nxt;
  logic signed [COORD_WIDTH-1:0] speed_r, speed_nxt;
  logic signed [ANGLE_WIDTH-1:0] turn_x_r, turn_x_nxt, turn_y_r, turn_y_nxt;
  logic signed [ANGLE_WIDTH-1:0] turn_z_r, turn_z_nxt;
  logic signed [SUM_W-1:0]       acc_r, acc_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]         out_data_r, out_data_nxt;

  // Shared units
  mul_req_t                      mul_req;
  logic signed [MA_W-1:0]        mul_a, mul_b;
  logic                          mul_done;
  logic signed [TERM_W-1:0]      mul_term;
  logic                          sc_start, sc_done;
  logic signed [T_W-1:0]         sin_v, cos_v;

  // Per-axis selection
  logic signed [ANGLE_WIDTH-1:0] angle_sel;
  logic signed [COORD_WIDTH-1:0] base_a, base_b;
  logic signed [V_W-1:0]         va, vb;
  logic signed [SUM_W-1:0]       term_ext;
  logic                          in_req;

  cetu_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .term  (mul_term)
  );

  cetu_sincos u_sincos (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sc_start),
    .angle   (angle_sel),
    .done    (sc_done),
    .sin_val (sin_v),
    .cos_val (cos_v)
  );

  assign in_tready = (state_r == ST_IDLE);
  assign in_req    = in_tvalid && in_tready;
  assign term_ext  = SUM_W'(mul_term);

  // Rotation operands: a = base_a + s*va + c*vb, b = base_b + c*va - s*vb
  always_comb begin
    case (axis_r)
      AX_X: begin
        angle_sel = turn_x_r;
        base_a    = eye_z_r;
        base_b    = eye_y_r;
        va        = v_y_r;
        vb        = v_z_r;
      end
      AX_Y: begin
        angle_sel = turn_y_r;
        base_a    = eye_z_r;
        base_b    = eye_x_r;
        va        = v_x_r;
        vb        = v_z_r;
      end
      default: begin
        angle_sel = turn_z_r;
        base_a    = eye_x_r;
        base_b    = eye_y_r;
        va        = v_y_r;
        vb        = v_x_r;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    axis_nxt      = axis_r;
    op_nxt        = op_r;
    eye_x_nxt     = eye_x_r;
    eye_y_nxt     = eye_y_r;
    eye_z_nxt     = eye_z_r;
    tgt_x_nxt     = tgt_x_r;
    tgt_y_nxt     = tgt_y_r;
    tgt_z_nxt     = tgt_z_r;
    v_x_nxt       = v_x_r;
    v_y_nxt       = v_y_r;
    v_z_nxt       = v_z_r;
    speed_nxt     = speed_r;
    turn_x_nxt    = turn_x_r;
    turn_y_nxt    = turn_y_r;
    turn_z_nxt    = turn_z_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_req.start = 1'b0;
    mul_req.trig  = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    sc_start      = 1'b0;

    // output register drains independently
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_req) begin
          op_nxt     = in_tuser;
          speed_nxt  = in_tdata[6*COORD_WIDTH +: COORD_WIDTH];
          turn_x_nxt = in_tdata[7*COORD_WIDTH +: ANGLE_WIDTH];
          turn_y_nxt = in_tdata[7*COORD_WIDTH + ANGLE_WIDTH +: ANGLE_WIDTH];
          turn_z_nxt = in_tdata[7*COORD_WIDTH + 2*ANGLE_WIDTH +: ANGLE_WIDTH];
          // view vector from the points before this request
          v_x_nxt    = V_W'(tgt_x_r) - V_W'(eye_x_r);
          v_y_nxt    = V_W'(tgt_y_r) - V_W'(eye_y_r);
          v_z_nxt    = V_W'(tgt_z_r) - V_W'(eye_z_r);
          state_nxt  = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (op_r)
          OP_PLACE: begin
            state_nxt = ST_DONE;
          end
          OP_MOVE: begin
            mul_req.start = 1'b1;
            mul_a         = MA_W'(v_x_r);
            mul_b         = MA_W'(speed_r);
            state_nxt     = ST_MOVE_X;
          end
          OP_ROTATE: begin
            axis_nxt  = AX_X;
            state_nxt = ST_AXIS;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_MOVE_X: begin
        if (mul_done) begin
          eye_x_nxt     = sat_coord(SUM_W'(eye_x_r) + term_ext);
          tgt_x_nxt     = sat_coord(SUM_W'(tgt_x_r) + term_ext);
          mul_req.start = 1'b1;
          mul_a         = MA_W'(v_z_r);
          mul_b         = MA_W'(speed_r);
          state_nxt     = ST_MOVE_Z;
        end
      end
      ST_MOVE_Z: begin
        if (mul_done) begin
          eye_z_nxt = sat_coord(SUM_W'(eye_z_r) + term_ext);
          tgt_z_nxt = sat_coord(SUM_W'(tgt_z_r) + term_ext);
          state_nxt = ST_DONE;
        end
      end
      ST_AXIS: begin
        if (axis_r == AX_END) begin
          state_nxt = ST_DONE;
        end else if (angle_sel == '0) begin
          axis_nxt = axis_r + 2'd1;
        end else begin
          sc_start  = 1'b1;
          state_nxt = ST_TRIG;
        end
      end
      ST_TRIG: begin
        if (sc_done) begin
          mul_req.start = 1'b1;
          mul_req.trig  = 1'b1;
          mul_a         = MA_W'(sin_v);
          mul_b         = MA_W'(va);
          state_nxt     = ST_P0;
        end
      end
      ST_P0: begin
        if (mul_done) begin
          acc_nxt       = SUM_W'(base_a) + term_ext;
          mul_req.start = 1'b1;
          mul_req.trig  = 1'b1;
          mul_a         = MA_W'(cos_v);
          mul_b         = MA_W'(vb);
          state_nxt     = ST_P1;
        end
      end
      ST_P1: begin
        if (mul_done) begin
          // first component of the pair
          if (axis_r == AX_Z) begin
            tgt_x_nxt = sat_coord(acc_r + term_ext);
          end else begin
            tgt_z_nxt = sat_coord(acc_r + term_ext);
          end
          acc_nxt       = SUM_W'(base_b);
          mul_req.start = 1'b1;
          mul_req.trig  = 1'b1;
          mul_a         = MA_W'(cos_v);
          mul_b         = MA_W'(va);
          state_nxt     = ST_P2;
        end
      end
      ST_P2: begin
        if (mul_done) begin
          acc_nxt       = acc_r + term_ext;
          mul_req.start = 1'b1;
          mul_req.trig  = 1'b1;
          mul_a         = MA_W'(sin_v);
          mul_b         = MA_W'(vb);
          state_nxt     = ST_P3;
        end
      end
      ST_P3: begin
        if (mul_done) begin
          // second component of the pair
          if (axis_r == AX_Y) begin
            tgt_x_nxt = sat_coord(acc_r - term_ext);
          end else begin
            tgt_y_nxt = sat_coord(acc_r - term_ext);
          end
          axis_nxt  = axis_r + 2'd1;
          state_nxt = ST_AXIS;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({tgt_z_r, tgt_y_r, tgt_x_r,
                                       eye_z_r, eye_y_r, eye_x_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // place loads both points straight from the request
    if (in_req && (in_tuser == OP_PLACE)) begin
      eye_x_nxt = in_tdata[0*COORD_WIDTH +: COORD_WIDTH];
      eye_y_nxt = in_tdata[1*COORD_WIDTH +: COORD_WIDTH];
      eye_z_nxt = in_tdata[2*COORD_WIDTH +: COORD_WIDTH];
      tgt_x_nxt = in_tdata[3*COORD_WIDTH +: COORD_WIDTH];
      tgt_y_nxt = in_tdata[4*COORD_WIDTH +: COORD_WIDTH];
      tgt_z_nxt = in_tdata[5*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // Control and camera state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      axis_r      <= AX_X;
      out_valid_r <= 1'b0;
      eye_x_r     <= '0;
      eye_y_r     <= '0;
      eye_z_r     <= '0;
      tgt_x_r     <= '0;
      tgt_y_r     <= '0;
      tgt_z_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      axis_r      <= axis_nxt;
      out_valid_r <= out_valid_nxt;
      eye_x_r     <= eye_x_nxt;
      eye_y_r     <= eye_y_nxt;
      eye_z_r     <= eye_z_nxt;
      tgt_x_r     <= tgt_x_nxt;
      tgt_y_r     <= tgt_y_nxt;
      tgt_z_r     <= tgt_z_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    v_x_r      <= v_x_nxt;
    v_y_r      <= v_y_nxt;
    v_z_r      <= v_z_nxt;
    speed_r    <= speed_nxt;
    turn_x_r   <= turn_x_nxt;
    turn_y_r   <= turn_y_nxt;
    turn_z_r   <= turn_z_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Assertions
  `CETU_ASSERT_IMP(a_mul_consumer, clk, rst_n, mul_done, (state_r == ST_MOVE_X || state_r == ST_MOVE_Z || state_r == ST_P0 || state_r == ST_P1 || state_r == ST_P2 || state_r == ST_P3), "product finished with no state waiting for it")
  `CETU_ASSERT_IMP(a_trig_consumer, clk, rst_n, sc_done, state_r == ST_TRIG, "sine/cosine finished outside the trig wait state")
  `CETU_ASSERT_IMP(a_trig_angle, clk, rst_n, $rose(state_r == ST_TRIG), angle_sel != '0, "trig started for a zero angle")
  `CETU_ASSERT_NXT(a_result_posted, clk, rst_n, (state_r == ST_DONE && (!out_valid_r || out_tready)), (out_tvalid && state_r == ST_IDLE), "result not posted when output register was free")

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the camera eye/target update block. Place, move,
// rotate and undefined-operation requests are streamed in with random idle
// bursts on both sides. A behavioral camera tracks eye and target in Q16.16,
// with its own CORDIC sine/cosine and rounded products. Every returned pose is
// compared field by field with the oldest predicted pose.
// ----------------------------------------------------------------------------
module tb_top import cetu_pkg::*; ;

  // Operation code the block does not define: state is left as it is
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int AX = 0;
  localparam int AY = 1;
  localparam int AZ = 2;

  localparam int    RANDOM_REQS    = 1200;
  localparam int    QUIET_TAIL     = 150;
  localparam int    WATCHDOG_LIMIT = 2000;
  localparam int    DRAIN_CYCLES   = 200;
  localparam int    REPORT_MAX     = 10;
  localparam logic [31:0] ONE      = 32'h0001_0000;
  localparam logic [31:0] CMAX     = 32'h7fff_ffff;
  localparam logic [31:0] CMIN     = 32'h8000_0000;

  // Sine/cosine constants: angles in Q.30 radians, arctangent steps in Q.16
  localparam longint PI_R      = 64'sd3373259426;
  localparam longint HALF_PI_R = 64'sd1686629713;
  localparam longint TWO_PI_R  = 64'sd6746518852;
  localparam longint CORDIC_X0 = 64'sd652032874;
  localparam longint CLAMP_MAG = 64'sd1152921504606846976;
  localparam longint ATAN_STEP [16] = '{51472, 30386, 16055, 8150, 4091, 2047,
                                        1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct packed {
    logic [OP_W-1:0]                     op;
    logic [2:0][ANGLE_WIDTH-1:0]         turn;
    logic [COORD_WIDTH-1:0]              speed;
    logic [2:0][COORD_WIDTH-1:0]         view;
    logic [2:0][COORD_WIDTH-1:0]         pos;
  } cam_req_t;

  typedef struct packed {
    logic [2:0][COORD_WIDTH-1:0] target;
    logic [2:0][COORD_WIDTH-1:0] eye;
  } cam_pose_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic [OP_W-1:0]       in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  cam_req_t  cam_req_q[$];
  cam_pose_t pose_expected_q[$];
  longint    cam_eye[3]    = '{0, 0, 0};
  longint    cam_target[3] = '{0, 0, 0};
  string     pose_field[6] = '{"eye_x", "eye_y", "eye_z",
                               "target_x", "target_y", "target_z"};
  int        error_cnt  = 0;
  int        report_cnt = 0;
  int        in_gap_left     = 0;
  int        out_stall_left  = 0;
  int        quiet_cycles    = 0;

  camera_eye_target_update u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Camera predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_coord(input longint v);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
    lo = -hi - 1;
    return (v > hi) ? hi : ((v < lo) ? lo : v);
  endfunction

  // a*b / 2^sh, round half away from zero, magnitude clamped to 2^60
  function automatic longint scaled_product(input longint a, input longint b,
                                            input int sh);
    logic         neg;
    logic [127:0] ma;
    logic [127:0] mb;
    logic [127:0] prod;
    longint       mag;
    neg  = (a < 0) != (b < 0);
    ma   = (a < 0) ? 128'(-a) : 128'(a);
    mb   = (b < 0) ? 128'(-b) : 128'(b);
    prod = (ma * mb + (128'd1 << (sh - 1))) >> sh;
    mag  = (prod > 128'(CLAMP_MAG)) ? CLAMP_MAG : longint'(prod[63:0]);
    return neg ? -mag : mag;
  endfunction

  // Range reduce, fold to +-pi/2, then rotation-mode CORDIC in Q.30
  function automatic void cordic_sin_cos(input longint angle, output longint s_q30,
                                         output longint c_q30);
    longint r;
    longint x;
    longint y;
    longint z;
    longint nx;
    logic   flip;
    r    = (angle * 64'sd262144) % TWO_PI_R;
    flip = 1'b0;
    if (r > PI_R) r -= TWO_PI_R;
    if (r < -PI_R) r += TWO_PI_R;
    if (r > HALF_PI_R) begin
      r    = PI_R - r;
      flip = 1'b1;
    end else if (r < -HALF_PI_R) begin
      r    = -PI_R - r;
      flip = 1'b1;
    end
    z = (r + 64'sd8192) >>> 14;
    x = CORDIC_X0;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - ATAN_STEP[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + ATAN_STEP[i];
      end
      x = nx;
    end
    s_q30 = y;
    c_q30 = flip ? -x : x;
  endfunction

  // a = base_a + s*va + c*vb ; b = base_b + c*va - s*vb
  function automatic void turn_axis(input longint angle, input longint base_a,
                                    input longint base_b, input longint va,
                                    input longint vb, output longint a_out,
                                    output longint b_out);
    longint s;
    longint c;
    cordic_sin_cos(angle, s, c);
    a_out = clamp_coord(base_a + scaled_product(s, va, TRIG_FRAC)
                        + scaled_product(c, vb, TRIG_FRAC));
    b_out = clamp_coord(base_b + scaled_product(c, va, TRIG_FRAC)
                        - scaled_product(s, vb, TRIG_FRAC));
  endfunction

  function automatic cam_pose_t advance_camera(input cam_req_t req);
    longint    vec[3];
    longint    spd;
    longint    step_x;
    longint    step_z;
    longint    ang[3];
    cam_pose_t pose;
    for (int k = 0; k < 3; k++) begin
      vec[k] = cam_target[k] - cam_eye[k];
      ang[k] = longint'($signed(req.turn[k]));
    end
    case (req.op)
      OP_PLACE: begin
        for (int k = 0; k < 3; k++) begin
          cam_eye[k]    = longint'($signed(req.pos[k]));
          cam_target[k] = longint'($signed(req.view[k]));
        end
      end
      OP_MOVE: begin
        spd    = longint'($signed(req.speed));
        step_x = scaled_product(vec[AX], spd, COORD_FRAC);
        step_z = scaled_product(vec[AZ], spd, COORD_FRAC);
        cam_eye[AX]    = clamp_coord(cam_eye[AX] + step_x);
        cam_eye[AZ]    = clamp_coord(cam_eye[AZ] + step_z);
        cam_target[AX] = clamp_coord(cam_target[AX] + step_x);
        cam_target[AZ] = clamp_coord(cam_target[AZ] + step_z);
      end
      OP_ROTATE: begin
        // later axes overwrite what earlier ones wrote; all use the old vector
        if (ang[AX] != 0)
          turn_axis(ang[AX], cam_eye[AZ], cam_eye[AY], vec[AY], vec[AZ],
                    cam_target[AZ], cam_target[AY]);
        if (ang[AY] != 0)
          turn_axis(ang[AY], cam_eye[AZ], cam_eye[AX], vec[AX], vec[AZ],
                    cam_target[AZ], cam_target[AX]);
        if (ang[AZ] != 0)
          turn_axis(ang[AZ], cam_eye[AX], cam_eye[AY], vec[AY], vec[AX],
                    cam_target[AX], cam_target[AY]);
      end
      default: ;
    endcase
    for (int k = 0; k < 3; k++) begin
      pose.eye[k]    = COORD_WIDTH'(cam_eye[k]);
      pose.target[k] = COORD_WIDTH'(cam_target[k]);
    end
    return pose;
  endfunction

  // --------------------------------------------------------------------------
  // Request generation; unused fields carry random noise
  // --------------------------------------------------------------------------
  function automatic cam_req_t noise_req(input logic [OP_W-1:0] op);
    cam_req_t req;
    req.op = op;
    for (int k = 0; k < 3; k++) begin
      req.pos[k]  = $urandom();
      req.view[k] = $urandom();
      req.turn[k] = ANGLE_WIDTH'($urandom());
    end
    req.speed = $urandom();
    return req;
  endfunction

  task automatic push_place(input logic [31:0] ex, input logic [31:0] ey,
                            input logic [31:0] ez, input logic [31:0] tx,
                            input logic [31:0] ty, input logic [31:0] tz);
    cam_req_t req;
    req = noise_req(OP_PLACE);
    req.pos  = {ez, ey, ex};
    req.view = {tz, ty, tx};
    cam_req_q.push_back(req);
  endtask

  task automatic push_move(input logic [31:0] spd);
    cam_req_t req;
    req = noise_req(OP_MOVE);
    req.speed = spd;
    cam_req_q.push_back(req);
  endtask

  task automatic push_rotate(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az);
    cam_req_t req;
    req = noise_req(OP_ROTATE);
    req.turn = {az, ay, ax};
    cam_req_q.push_back(req);
  endtask

  function automatic logic [31:0] rand_coord();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return 32'($urandom_range(0, 32'h0040_0000)) - 32'h0020_0000;
    if (sel < 8) return 32'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000;
    return $urandom();
  endfunction

  function automatic logic [31:0] rand_speed();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
    if (sel < 9) return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    return $urandom();
  endfunction

  function automatic logic [15:0] rand_angle();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return 16'd0;
    if (sel < 8) return 16'($urandom_range(0, 16384)) - 16'd8192;
    return 16'($urandom());
  endfunction

  // --------------------------------------------------------------------------
  // Request driver
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive_requests
    logic next_valid;
    if (!rst_n) begin
      in_tvalid   <= 1'b0;
      in_gap_left  = 0;
    end else begin
      if (in_tvalid && in_tready)
        pose_expected_q.push_back(advance_camera(cam_req_q.pop_front()));
      if (!in_tvalid || in_tready) begin
        next_valid = 1'b0;
        if (in_gap_left > 0) begin
          in_gap_left--;
        end else if (cam_req_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
          in_gap_left = $urandom_range(1, 7) - 1;
        end else if (cam_req_q.size() > 0) begin
          next_valid = 1'b1;
          in_tdata  <= IN_DATA_W'({cam_req_q[0].turn, cam_req_q[0].speed,
                                   cam_req_q[0].view, cam_req_q[0].pos});
          in_tuser  <= cam_req_q[0].op;
        end
        in_tvalid <= next_valid;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pose monitor and checker
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_poses
    logic [5:0][COORD_WIDTH-1:0] exp_flat;
    logic [5:0][COORD_WIDTH-1:0] got_flat;
    if (!rst_n) begin
      out_tready    <= 1'b0;
      out_stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_flat = out_tdata[6*COORD_WIDTH-1:0];
        if (pose_expected_q.size() == 0) begin
          error_cnt++;
          if (report_cnt < REPORT_MAX) begin
            report_cnt++;
            $display("unexpected pose at %0t: %h", $realtime, out_tdata);
          end
        end else begin
          exp_flat = pose_expected_q.pop_front();
          for (int k = 0; k < 6; k++) begin
            if (got_flat[k] !== exp_flat[k]) begin
              error_cnt++;
              if (report_cnt < REPORT_MAX) begin
                report_cnt++;
                $display("%s mismatch at %0t: expected %0d, got %0d", pose_field[k],
                         $realtime, $signed(exp_flat[k]), $signed(got_flat[k]));
              end
            end
          end
        end
      end
      // random backpressure bursts, none near the end
      if (out_stall_left > 0) begin
        out_stall_left--;
        out_tready <= 1'b0;
      end else if (cam_req_q.size() > QUIET_TAIL && $urandom_range(0, 5) == 0) begin
        out_stall_left = $urandom_range(1, 7) - 1;
        out_tready    <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: cycles with no request taken and no pose returned
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** camera_eye_target_update: FAILED **");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of run
  // --------------------------------------------------------------------------
  initial begin
    int n;
    // directed: moves and rotates on the all-zero reset pose
    push_move(ONE);
    push_rotate(16'd4096, 16'd4096, 16'd4096);
    push_place(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 6 * ONE, 3 * ONE);
    push_move(ONE);
    push_move(-(ONE / 2));
    push_rotate(16'd0, 16'd0, 16'd0);
    push_rotate(16'd6434, 16'd0, 16'd0);
    push_rotate(16'd0, -16'sd6434, 16'd0);
    push_rotate(16'd0, 16'd0, 16'd12868);
    push_rotate(16'h7fff, 16'h8000, 16'd1);
    push_rotate(16'h8000, 16'h7fff, 16'hffff);
    push_rotate(16'd1000, 16'd2000, -16'sd3000);
    push_rotate(16'd6433, -16'sd6433, -16'sd12868);
    // extremes and saturation
    push_place(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
    push_move(CMAX);
    push_place(CMIN, 32'd0, CMAX, CMAX, 32'd0, CMIN);
    push_move(CMIN);
    push_rotate(16'd6434, 16'd6434, 16'd6434);
    push_place(32'd0, 32'd0, 32'd0, CMAX, CMIN, CMAX);
    push_rotate(16'd3217, 16'd9651, -16'sd3217);
    cam_req_q.push_back(noise_req(OP_UNUSED));
    push_place(5 * ONE, -(2 * ONE), ONE, -(ONE / 3), 7 * ONE, -(4 * ONE));
    push_move(32'd0);
    cam_req_q.push_back(noise_req(OP_UNUSED));

    // random: place, then a run of moves, rotates and undefined operations on that pose
    n = 0;
    while (n < RANDOM_REQS) begin
      push_place(rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
      n++;
      repeat ($urandom_range(2, 12)) begin
        case ($urandom_range(0, 19))
          0:                 cam_req_q.push_back(noise_req(OP_UNUSED));
          1, 2, 3, 4, 5, 6, 7,
          8:                 push_move(rand_speed());
          default:           push_rotate(rand_angle(), rand_angle(), rand_angle());
        endcase
        n++;
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (cam_req_q.size() != 0 || pose_expected_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("** camera_eye_target_update: PASSED **");
    end else begin
      $display("** camera_eye_target_update: FAILED **");
    end
    $finish;
  end

endmodule
